@@ rtl/core/brs_pkg.sv @@
// brs_pkg: shared types and constants of the bilinear rgba scaler
// no dependencies; used by brs_frame_store and bilinear_rgba_scaler_top
package brs_pkg;

   localparam int CHAN_W  = 8;
   localparam int NUM_CHAN = 4;
   localparam int PIXEL_W = CHAN_W * NUM_CHAN;
   localparam int FRAC_W  = 16;
   localparam int SIZE_W  = 8;
   localparam int STEP_W  = 23;
   localparam int COORD_W = 12;
   localparam int LOAD_W  = 7;
   localparam int POS_W   = COORD_W + STEP_W;
   localparam int LIM_W   = SIZE_W + FRAC_W;

   typedef enum logic {
      KIND_LOAD    = 1'b0,
      KIND_REQUEST = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_STEP_X        = 2'd2,
      CSR_STEP_Y        = 2'd3
   } csr_index_type;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // 2x2 neighborhood: p<row><col>
   typedef struct packed {
      pixel_type p11;
      pixel_type p10;
      pixel_type p01;
      pixel_type p00;
   } quad_type;

endpackage

@@ rtl/core/brs_frame_store.sv @@
// brs_frame_store: source frame held in four identical banks, one per neighbor read
// depends on brs_pkg for the pixel and neighborhood types
module brs_frame_store #(
   parameter int AW    = 14,
   parameter int DEPTH = 16384
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  brs_pkg::pixel_type   wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr [4],
   output brs_pkg::quad_type    rd_data
);
   import brs_pkg::*;

   pixel_type rd_q_ff [4];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      pixel_type mem [DEPTH];

      // every bank takes every write so all four copies stay equal
      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rd_q_ff[b] <= mem[rd_addr[b]];
         end
      end
   end

   assign rd_data.p00 = rd_q_ff[0];
   assign rd_data.p01 = rd_q_ff[1];
   assign rd_data.p10 = rd_q_ff[2];
   assign rd_data.p11 = rd_q_ff[3];

endmodule

@@ rtl/core/bilinear_rgba_scaler_top.sv @@
// Bilinear RGBA scaler, steps in 7.16 fixed point. Load transfers (tuser 0) write one 32-bit source
// pixel into the frame store; request transfers (tuser 1) return one interpolated pixel for
// destination (x, y), with the source position clamped to the image and the 2x2
// neighborhood held at the right and bottom edges. The block takes one transfer per clock
// when the output is not stalled; the pace is set by the frame store, which keeps four
// copies of the source image so that all four neighbors are read in the same cycle. Five
// register stages: position multiply, clamp and neighbor select, frame store access,
// horizontal blend, vertical blend. Registers must be written only while no transfer is
// in flight; the block itself does not enforce this. Source pixels must be loaded before
// a request reads them.
// depends on brs_pkg and brs_frame_store
module bilinear_rgba_scaler_top #(
   parameter int SRC_MAX_W = 128,
   parameter int SRC_MAX_H = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // src_col[6:0], src_row[13:7], src_pixel[45:14], dst_x[57:46], dst_y[69:58], zero fill
   input  logic [71:0]                 req_tdata,
   // kind[0]
   input  logic                        req_tuser,
   // result channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // out_pixel[31:0], out_x[43:32], out_y[55:44]
   output logic [55:0]                 rsp_tdata,
   // register write port
   input  logic                        csr_we,
   input  brs_pkg::csr_index_type      csr_addr,
   input  logic [brs_pkg::STEP_W-1:0]  csr_wdata
);
   import brs_pkg::*;

   localparam int CW    = (SRC_MAX_W > 1) ? $clog2(SRC_MAX_W) : 1;
   localparam int RW    = (SRC_MAX_H > 1) ? $clog2(SRC_MAX_H) : 1;
   localparam int AW    = CW + RW;
   localparam int DEPTH = SRC_MAX_H * (2 ** CW);
   localparam logic [SIZE_W-1:0] W_CAP = (SRC_MAX_W > 255) ? 8'd255 : SIZE_W'(SRC_MAX_W);
   localparam logic [SIZE_W-1:0] H_CAP = (SRC_MAX_H > 255) ? 8'd255 : SIZE_W'(SRC_MAX_H);

   // ---------------- registers ----------------
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [STEP_W-1:0] step_x_ff, step_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'd128;
         height_ff <= 8'd128;
         step_x_ff <= 23'd65536;
         step_y_ff <= 23'd65536;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SOURCE_WIDTH:  width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_SOURCE_HEIGHT: height_ff <= csr_wdata[SIZE_W-1:0];
            CSR_STEP_X:        step_x_ff <= csr_wdata;
            CSR_STEP_Y:        step_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [SIZE_W-1:0] w_eff, h_eff;
   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0)     w_eff = 8'd1;
      else if (width_ff > W_CAP) w_eff = W_CAP;
      h_eff = height_ff;
      if (height_ff == '0)      h_eff = 8'd1;
      else if (height_ff > H_CAP) h_eff = H_CAP;
   end

   // ---------------- blend functions ----------------
   // floor((b - a) * frac / 65536) + a, low 8 bits
   function automatic logic [CHAN_W-1:0] lerp8(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b,
                                               input logic [FRAC_W-1:0] frac);
      logic signed [CHAN_W:0]          d;
      logic signed [CHAN_W+FRAC_W+1:0] p;
      d = $signed({1'b0, b}) - $signed({1'b0, a});
      p = d * $signed({1'b0, frac});
      return p[FRAC_W+CHAN_W-1:FRAC_W] + a;
   endfunction

   function automatic pixel_type lerp_pixel(input pixel_type a, input pixel_type b,
                                            input logic [FRAC_W-1:0] frac);
      pixel_type r;
      for (int c = 0; c < NUM_CHAN; c++) begin
         r[c*CHAN_W +: CHAN_W] = lerp8(a[c*CHAN_W +: CHAN_W], b[c*CHAN_W +: CHAN_W], frac);
      end
      return r;
   endfunction

   // ---------------- stall chain ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic en1, en2, en3, en4, en5;

   assign en5 = !v5_ff || rsp_tready;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   // ---------------- stage 1: position multiply ----------------
   kind_type            kind1_ff;
   logic [LOAD_W-1:0]   col1_ff, row1_ff;
   pixel_type           pix1_ff;
   logic [COORD_W-1:0]  dx1_ff, dy1_ff;
   logic [POS_W-1:0]    px1_ff, py1_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         kind1_ff <= kind_type'(req_tuser);
         col1_ff  <= req_tdata[6:0];
         row1_ff  <= req_tdata[13:7];
         pix1_ff  <= req_tdata[45:14];
         dx1_ff   <= req_tdata[57:46];
         dy1_ff   <= req_tdata[69:58];
         px1_ff   <= POS_W'(req_tdata[57:46]) * POS_W'(step_x_ff);
         py1_ff   <= POS_W'(req_tdata[69:58]) * POS_W'(step_y_ff);
      end
   end

   // ---------------- stage 2: clamp, neighbor select ----------------
   kind_type            kind2_ff;
   logic                ld_ok2_ff;
   logic [AW-1:0]       wr_addr2_ff;
   pixel_type           pix2_ff;
   logic [COORD_W-1:0]  dx2_ff, dy2_ff;
   logic [SIZE_W-1:0]   cx2_ff, nx2_ff, cy2_ff, ny2_ff;
   logic [FRAC_W-1:0]   ex2_ff, ey2_ff;

   logic [LIM_W-1:0]    lim_x, lim_y, pxc, pyc;
   logic [SIZE_W-1:0]   cx_in, cy_in, nx_in, ny_in;
   logic                ld_ok_in;

   always_comb begin
      lim_x = {w_eff - 8'd1, 16'hffff};
      lim_y = {h_eff - 8'd1, 16'hffff};
      pxc   = (px1_ff > POS_W'(lim_x)) ? lim_x : px1_ff[LIM_W-1:0];
      pyc   = (py1_ff > POS_W'(lim_y)) ? lim_y : py1_ff[LIM_W-1:0];
      cx_in = pxc[LIM_W-1:FRAC_W];
      cy_in = pyc[LIM_W-1:FRAC_W];
      nx_in = (cx_in < w_eff - 8'd1) ? cx_in + 8'd1 : cx_in;
      ny_in = (cy_in < h_eff - 8'd1) ? cy_in + 8'd1 : cy_in;
      // loads outside the store are dropped
      ld_ok_in = (32'(col1_ff) < SRC_MAX_W) && (32'(row1_ff) < SRC_MAX_H);
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         kind2_ff    <= kind1_ff;
         ld_ok2_ff   <= ld_ok_in;
         wr_addr2_ff <= {RW'(row1_ff), CW'(col1_ff)};
         pix2_ff     <= pix1_ff;
         dx2_ff      <= dx1_ff;
         dy2_ff      <= dy1_ff;
         cx2_ff      <= cx_in;
         nx2_ff      <= nx_in;
         cy2_ff      <= cy_in;
         ny2_ff      <= ny_in;
         ex2_ff      <= pxc[FRAC_W-1:0];
         ey2_ff      <= pyc[FRAC_W-1:0];
      end
   end

   // ---------------- stage 3: frame store access ----------------
   logic          st_wr_en;
   logic [AW-1:0] st_rd_addr [4];
   quad_type      quad3;

   assign st_wr_en      = en3 && v2_ff && (kind2_ff == KIND_LOAD) && ld_ok2_ff;
   assign st_rd_addr[0] = {RW'(cy2_ff), CW'(cx2_ff)};
   assign st_rd_addr[1] = {RW'(cy2_ff), CW'(nx2_ff)};
   assign st_rd_addr[2] = {RW'(ny2_ff), CW'(cx2_ff)};
   assign st_rd_addr[3] = {RW'(ny2_ff), CW'(nx2_ff)};

   brs_frame_store #(
      .AW    (AW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (wr_addr2_ff),
      .wr_data (pix2_ff),
      .rd_en   (en3),
      .rd_addr (st_rd_addr),
      .rd_data (quad3)
   );

   logic [COORD_W-1:0] dx3_ff, dy3_ff;
   logic [FRAC_W-1:0]  ex3_ff, ey3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         dx3_ff <= dx2_ff;
         dy3_ff <= dy2_ff;
         ex3_ff <= ex2_ff;
         ey3_ff <= ey2_ff;
      end
   end

   // ---------------- stage 4: horizontal blend ----------------
   pixel_type          top4_ff, bot4_ff;
   logic [COORD_W-1:0] dx4_ff, dy4_ff;
   logic [FRAC_W-1:0]  ey4_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         top4_ff <= lerp_pixel(quad3.p00, quad3.p01, ex3_ff);
         bot4_ff <= lerp_pixel(quad3.p10, quad3.p11, ex3_ff);
         dx4_ff  <= dx3_ff;
         dy4_ff  <= dy3_ff;
         ey4_ff  <= ey3_ff;
      end
   end

   // ---------------- stage 5: vertical blend, output register ----------------
   pixel_type          out5_ff;
   logic [COORD_W-1:0] dx5_ff, dy5_ff;

   always_ff @(posedge clock) begin
      if (en5) begin
         out5_ff <= lerp_pixel(top4_ff, bot4_ff, ey4_ff);
         dx5_ff  <= dx4_ff;
         dy5_ff  <= dy4_ff;
      end
   end

   // ---------------- valid bits ----------------
   always_comb begin
      v1_in = en1 ? req_tvalid : v1_ff;
      v2_in = en2 ? v1_ff : v2_ff;
      // loads retire at the store write
      v3_in = en3 ? (v2_ff && (kind2_ff == KIND_REQUEST)) : v3_ff;
      v4_in = en4 ? v3_ff : v4_ff;
      v5_in = en5 ? v4_ff : v5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {dy5_ff, dx5_ff, out5_ff};

`ifndef SYNTHESIS
   a_pos_in_image: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && kind2_ff == KIND_REQUEST) |-> (cx2_ff < w_eff && cy2_ff < h_eff))
      else $error("clamped source position outside the image");

   a_neighbor_held: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && kind2_ff == KIND_REQUEST) |->
         ((nx2_ff == cx2_ff || nx2_ff == cx2_ff + 8'd1) && nx2_ff < w_eff &&
          (ny2_ff == cy2_ff || ny2_ff == cy2_ff + 8'd1) && ny2_ff < h_eff))
      else $error("right or lower neighbor outside the image");

   a_blend_hold: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !en4) |=> (v4_ff && $stable(top4_ff) && $stable(bot4_ff)))
      else $error("stalled horizontal blend stage lost its data");
`endif

endmodule

@@ bench/brs_checker.sv @@
`timescale 1ns / 1ps
// brs_checker: watches the register port and both stream channels of the bilinear rgba
// scaler, predicts every destination pixel and compares it; depends on brs_pkg only
module brs_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [71:0]                 req_tdata,
   input  logic                        req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [55:0]                 rsp_tdata,
   input  logic                        csr_we,
   input  brs_pkg::csr_index_type      csr_addr,
   input  logic [brs_pkg::STEP_W-1:0]  csr_wdata,
   output int                          mismatch_count,
   output int                          pending_count,
   output int                          checked_count
);
   import brs_pkg::*;

   localparam int FRAME_W = 128;
   localparam int FRAME_H = 128;

   typedef struct packed {
      pixel_type            pixel;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
   } dest_pixel_type;

   pixel_type          frame_copy [FRAME_W*FRAME_H];
   logic [SIZE_W-1:0]  width_reg;
   logic [SIZE_W-1:0]  height_reg;
   logic [STEP_W-1:0]  step_x_reg;
   logic [STEP_W-1:0]  step_y_reg;
   dest_pixel_type     pending_pixels [$];

   function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int limit);
      if (v == 0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   // floor blend: a + floor((b - a) * frac / 2^16), wrapped to a channel
   function automatic logic [CHAN_W-1:0] blend(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b,
                                                input logic [FRAC_W-1:0] frac);
      longint prod;
      prod = (longint'(b) - longint'(a)) * longint'(frac);
      return CHAN_W'((prod >>> FRAC_W) + longint'(a));
   endfunction

   function automatic longint source_position(input logic [COORD_W-1:0] coord,
                                              input logic [STEP_W-1:0] step,
                                              input int size);
      longint pos;
      longint limit;
      pos = longint'(coord) * longint'(step);
      limit = (longint'(size) << FRAC_W) - 1;
      return (pos > limit) ? limit : pos;
   endfunction

   function automatic pixel_type interpolate_pixel(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
      int                 w, h, cx, cy, nx, ny;
      longint             px, py;
      logic [FRAC_W-1:0]  ex, ey;
      pixel_type          p00, p01, p10, p11, res;
      logic [CHAN_W-1:0]  top_c, bot_c;
      w = clamp_size(width_reg, FRAME_W);
      h = clamp_size(height_reg, FRAME_H);
      px = source_position(x, step_x_reg, w);
      py = source_position(y, step_y_reg, h);
      cx = int'(px >> FRAC_W);
      cy = int'(py >> FRAC_W);
      ex = px[FRAC_W-1:0];
      ey = py[FRAC_W-1:0];
      // neighbors held at the right and bottom edges
      nx = (cx < w - 1) ? cx + 1 : cx;
      ny = (cy < h - 1) ? cy + 1 : cy;
      p00 = frame_copy[cy*FRAME_W + cx];
      p01 = frame_copy[cy*FRAME_W + nx];
      p10 = frame_copy[ny*FRAME_W + cx];
      p11 = frame_copy[ny*FRAME_W + nx];
      res = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         top_c = blend(p00[c*CHAN_W +: CHAN_W], p01[c*CHAN_W +: CHAN_W], ex);
         bot_c = blend(p10[c*CHAN_W +: CHAN_W], p11[c*CHAN_W +: CHAN_W], ex);
         res[c*CHAN_W +: CHAN_W] = blend(top_c, bot_c, ey);
      end
      return res;
   endfunction

   task automatic check_field(input string field, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, expected, actual);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      dest_pixel_type due;
      if (reset) begin
         width_reg = 8'd128;
         height_reg = 8'd128;
         step_x_reg = 23'd65536;
         step_y_reg = 23'd65536;
         pending_pixels.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_SOURCE_WIDTH:  width_reg = csr_wdata[SIZE_W-1:0];
               CSR_SOURCE_HEIGHT: height_reg = csr_wdata[SIZE_W-1:0];
               CSR_STEP_X:        step_x_reg = csr_wdata;
               CSR_STEP_Y:        step_y_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pixels.size() == 0) begin
               $display("%0t: result with no request waiting, expected none, got %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               due = pending_pixels.pop_front();
               check_field("out_pixel", due.pixel, rsp_tdata[31:0]);
               check_field("out_x", 32'(due.x), 32'(rsp_tdata[43:32]));
               check_field("out_y", 32'(due.y), 32'(rsp_tdata[55:44]));
               checked_count++;
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_LOAD) begin
               frame_copy[int'(req_tdata[13:7])*FRAME_W + int'(req_tdata[6:0])] =
                  req_tdata[45:14];
            end else begin
               due.pixel = interpolate_pixel(req_tdata[57:46], req_tdata[69:58]);
               due.x = req_tdata[57:46];
               due.y = req_tdata[69:58];
               pending_pixels.insert(pending_pixels.size(), due);
            end
         end
      end
      pending_count <= pending_pixels.size();
   end

endmodule

@@ bench/bilinear_rgba_scaler_top_test.sv @@
`timescale 1ns / 1ps
// bilinear_rgba_scaler_top_test: loads source images, sweeps sizes and steps, and requests
// destination pixels under random idling; depends on brs_pkg, brs_checker and the scaler
module bilinear_rgba_scaler_top_test;
   import brs_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int MIX_TARGET  = 400;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [71:0]         req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [55:0]         rsp_tdata;
   logic                csr_we = 1'b0;
   csr_index_type       csr_addr = CSR_SOURCE_WIDTH;
   logic [STEP_W-1:0]   csr_wdata = '0;

   int mismatch_count;
   int pending_count;
   int checked_count;

   int  sender_pct = 0;
   int  receiver_pct = 0;
   int  cycle_count = 0;
   int  hold_left = 0;
   bit  hold_request = 1'b0;
   bit  hold_served = 1'b0;
   bit  loaded [128][128];
   int  cur_w, cur_h, cur_sx, cur_sy;
   int  load_count = 0;
   int  request_count = 0;
   int  mix_count = 0;
   int  setting_count = 0;

   bilinear_rgba_scaler_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   brs_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stalls plus one long hold-off to back up the pipeline
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_served) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_served <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_pct);
      end
   end

   task automatic push_transfer(input kind_type kind, input logic [71:0] data);
      while ($urandom_range(99) < sender_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load_pixel(input int col, input int row, input pixel_type pix);
      push_transfer(KIND_LOAD, {2'b0, 12'd0, 12'd0, pix, 7'(row), 7'(col)});
      loaded[row][col] = 1'b1;
      load_count++;
   endtask

   task automatic request_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
      push_transfer(KIND_REQUEST, {2'b0, y, x, 32'd0, 7'd0, 7'd0});
      request_count++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [STEP_W-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   function automatic int effective_size(input int v);
      if (v == 0) return 1;
      if (v > 128) return 128;
      return v;
   endfunction

   // registers change only with the pipeline empty, loads included
   task automatic configure(input int w, input int h, input int sx, input int sy);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      write_reg(CSR_SOURCE_WIDTH, STEP_W'(w));
      write_reg(CSR_SOURCE_HEIGHT, STEP_W'(h));
      write_reg(CSR_STEP_X, STEP_W'(sx));
      write_reg(CSR_STEP_Y, STEP_W'(sy));
      csr_we <= 1'b0;
      cur_w = effective_size(w);
      cur_h = effective_size(h);
      cur_sx = sx;
      cur_sy = sy;
      setting_count++;
   endtask

   function automatic pixel_type random_pixel();
      pixel_type pix;
      pix = $urandom();
      if ($urandom_range(3) == 0) begin
         for (int c = 0; c < NUM_CHAN; c++)
            pix[c*CHAN_W +: CHAN_W] = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
      end
      return pix;
   endfunction

   function automatic int random_step(input int size);
      int r;
      r = $urandom_range(99);
      if (r < 55) return ((size - 1) * 65536) / ($urandom_range(2, 300) - 1);
      if (r < 70) return $urandom_range(8388607);
      if (r < 80) return 0;
      if (r < 90) return 8388607;
      return 65536;
   endfunction

   // mostly inside the source image, some past the clamp and some anywhere
   function automatic logic [COORD_W-1:0] random_dst(input int size, input int step);
      longint reach;
      int     r;
      r = $urandom_range(99);
      if (r < 10) return ($urandom_range(1) != 0) ? 12'hfff : 12'h000;
      if (r < 25 || step == 0) return 12'($urandom_range(4095));
      reach = ((longint'(size) << 16) - 1) / step + 1;
      if (reach > 4095) reach = 4095;
      return 12'($urandom_range(int'(reach)));
   endfunction

   task automatic fill_image();
      for (int r = 0; r < cur_h; r++)
         for (int c = 0; c < cur_w; c++)
            if (!loaded[r][c]) load_pixel(c, r, random_pixel());
   endtask

   task automatic run_mix(input int n);
      for (int i = 0; i < n; i++) begin
         sender_pct = (mix_count < 133) ? 7 : (mix_count < 266) ? 48 : 0;
         receiver_pct = (mix_count < 133) ? 48 : (mix_count < 266) ? 7 : 0;
         if ($urandom_range(4) == 0) begin
            if ($urandom_range(1) != 0)
               load_pixel($urandom_range(cur_w - 1), $urandom_range(cur_h - 1), random_pixel());
            else
               load_pixel($urandom_range(127), $urandom_range(127), random_pixel());
         end else begin
            request_pixel(random_dst(cur_w, cur_sx), random_dst(cur_h, cur_sy));
         end
         mix_count++;
      end
   endtask

   task automatic run_phase(input int w, input int h, input int n);
      configure(w, h, random_step(effective_size(w)), random_step(effective_size(h)));
      fill_image();
      run_mix(n);
   endtask

   initial begin
      int w, h;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // 2x2 image with opposite corners, fractions of one half
      configure(2, 2, 32768, 32768);
      load_pixel(0, 0, 32'h0000_0000);
      load_pixel(1, 0, 32'hffff_ffff);
      load_pixel(0, 1, 32'hff00_ff00);
      load_pixel(1, 1, 32'h00ff_00ff);
      load_pixel(127, 127, 32'hffff_ffff);
      request_pixel(12'd0, 12'd0);
      request_pixel(12'd1, 12'd0);
      request_pixel(12'd0, 12'd1);
      request_pixel(12'd1, 12'd1);
      request_pixel(12'd2, 12'd3);
      request_pixel(12'hfff, 12'hfff);
      request_pixel(12'hfff, 12'd0);
      request_pixel(12'd0, 12'hfff);
      // zero step pins to column 0, largest step clamps to the last row
      configure(2, 2, 0, 8388607);
      request_pixel(12'hfff, 12'd1);
      request_pixel(12'd1, 12'hfff);
      request_pixel(12'd0, 12'd0);
      // zero size acts as one pixel
      configure(0, 0, 65536, 65536);
      request_pixel(12'd3, 12'd3);
      request_pixel(12'hfff, 12'hfff);

      // full-width row with the long hold-off on the result side
      configure(128, 1, random_step(128), random_step(1));
      fill_image();
      hold_request = 1'b1;
      run_mix(40);
      run_phase(255, 1, 30);
      run_phase(1, 128, 40);
      run_phase(0, 200, 25);
      run_phase(128, 2, 30);
      while (mix_count < MIX_TARGET) begin
         w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 12);
         h = $urandom_range(1, 60 / effective_size(w));
         run_phase(w, h, $urandom_range(25, 45));
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d source loads and %0d destination requests over %0d register settings",
               load_count, request_count, setting_count);
      $display("%0d interpolated pixels checked, %0d mismatches", checked_count,
               mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
